// ===== sv/dccrx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DCC packet receiver package
// Shared sizes, reset values and the structure that hands a finished packet
// from the bit receiver to the output run buffer.
// ----------------------------------------------------------------------------
package dccrx_pkg;

	// Largest packet, checksum byte included, that the receiver stores.
	localparam int MAX_BYTES = 6;

	// Width of a byte count that can hold MAX_BYTES itself.
	localparam int CNT_W = $clog2(MAX_BYTES + 1);

	// Width of an index into the packet store.
	localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

	// Width of the byte index and byte count fields on the output port.
	localparam int FLD_W = 3;

	localparam int THR_W = 5;
	localparam logic [THR_W-1:0] THRESH_RESET = 5'd10;

	typedef logic [7:0] octet_t;

	typedef logic [MAX_BYTES-1:0][7:0] pkt_bytes_t;

	// One complete packet, handed over on the end bit.
	typedef struct packed {
		logic             emit;
		pkt_bytes_t       bytes;
		logic [CNT_W-1:0] count;
		logic             xor_ok;
		octet_t           preamble;
	} run_load_t;

endpackage
`default_nettype wire

// ===== sv/dccrx_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DCC line sample channel
// Carries one sampled line level per word.
// ----------------------------------------------------------------------------
interface dccrx_in_if;
	logic valid;
	logic ready;
	logic line_level;

	modport source (output valid, output line_level, input ready);
	modport sink (input valid, input line_level, output ready);
endinterface
`default_nettype wire

// ===== sv/dccrx_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the preamble threshold register write data.
// ----------------------------------------------------------------------------
interface dccrx_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/dccrx_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Packet byte channel
// Carries one received packet byte and its packet information per word.
// ----------------------------------------------------------------------------
interface dccrx_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] packet_byte;
	logic [2:0] byte_index;
	logic [2:0] byte_count;
	logic       last_byte;
	logic       checksum_ok;
	logic [7:0] preamble_length;

	modport source (output valid, output packet_byte, output byte_index,
		output byte_count, output last_byte, output checksum_ok,
		output preamble_length, input ready);
	modport sink (input valid, input packet_byte, input byte_index,
		input byte_count, input last_byte, input checksum_ok,
		input preamble_length, output ready);
endinterface
`default_nettype wire

// ===== sv/dccrx_bit_rx.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DCC bit receiver
// Preamble hunt, start bit, byte assembly and packet store. Hands a finished
// packet to the run buffer on the end bit.
// ----------------------------------------------------------------------------
module dccrx_bit_rx import dccrx_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             line_level,
	output      logic             in_ready,
	input  wire logic             cfg_valid,
	input  wire logic [THR_W-1:0] cfg_data,
	input  wire logic             run_busy,
	output      run_load_t        load
);

	localparam logic [1:0] PH_PRE   = 2'd0;
	localparam logic [1:0] PH_START = 2'd1;
	localparam logic [1:0] PH_DATA  = 2'd2;
	localparam logic [1:0] PH_END   = 2'd3;

	localparam octet_t BITS_PER_BYTE = 8'd8;

	logic [1:0]       phase_q, phase_d;
	octet_t           cnt_q, cnt_d, cnt_inc;
	octet_t           shift_q, shift_d, shift_nx;
	logic [CNT_W-1:0] stored_q, stored_d;
	octet_t           pre_q, pre_d;
	octet_t           xor_q, xor_d;
	logic [THR_W-1:0] thr_q;
	pkt_bytes_t       store_q;
	logic             one, acc, wr_en, emit;

	assign one      = ~line_level;
	assign in_ready = !(run_busy && (phase_q == PH_END));
	assign acc      = in_valid && in_ready;
	assign cnt_inc  = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;
	assign shift_nx = {shift_q[6:0], one};

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		shift_d  = shift_q;
		stored_d = stored_q;
		pre_d    = pre_q;
		xor_d    = xor_q;
		wr_en    = 1'b0;
		emit     = 1'b0;
		case (phase_q)
			PH_PRE: begin
				if (one) begin
					cnt_d = cnt_inc;
					if (cnt_inc > {3'b000, thr_q}) begin
						phase_d = PH_START;
					end
				end else begin
					cnt_d = '0;
				end
			end
			PH_START: begin
				if (one) begin
					cnt_d = cnt_inc;
				end else begin
					pre_d    = cnt_q;
					stored_d = '0;
					xor_d    = '0;
					cnt_d    = '0;
					shift_d  = '0;
					phase_d  = PH_DATA;
				end
			end
			PH_DATA: begin
				shift_d = shift_nx;
				cnt_d   = cnt_q + 8'd1;
				if (cnt_d >= BITS_PER_BYTE) begin
					if (stored_q >= CNT_W'(MAX_BYTES)) begin
						// Packet too long for the store: drop it.
						phase_d = PH_PRE;
						cnt_d   = '0;
						shift_d = '0;
					end else begin
						wr_en    = 1'b1;
						xor_d    = xor_q ^ shift_nx;
						stored_d = stored_q + CNT_W'(1);
						phase_d  = PH_END;
					end
				end
			end
			PH_END: begin
				if (one) begin
					emit    = 1'b1;
					phase_d = PH_PRE;
				end else begin
					phase_d = PH_DATA;
				end
				cnt_d   = '0;
				shift_d = '0;
			end
			default: begin
				phase_d = PH_PRE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PRE;
			cnt_q    <= '0;
			shift_q  <= '0;
			stored_q <= '0;
			pre_q    <= '0;
			xor_q    <= '0;
			thr_q    <= THRESH_RESET;
		end else begin
			if (acc) begin
				phase_q  <= phase_d;
				cnt_q    <= cnt_d;
				shift_q  <= shift_d;
				stored_q <= stored_d;
				pre_q    <= pre_d;
				xor_q    <= xor_d;
			end
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
		end
	end

	// Packet store: entries are always written before they are read out.
	always_ff @(posedge clk) begin
		if (acc && wr_en) begin
			store_q[stored_q[IDX_W-1:0]] <= shift_nx;
		end
	end

	always_comb begin
		load.emit     = acc && emit;
		load.bytes    = store_q;
		load.count    = stored_q;
		load.xor_ok   = (xor_q == 8'h00);
		load.preamble = pre_q;
	end

endmodule
`default_nettype wire

// ===== sv/dccrx_run_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DCC packet run buffer
// Holds a copy of a finished packet and plays it out one byte per word.
// ----------------------------------------------------------------------------
module dccrx_run_buf import dccrx_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire run_load_t        load,
	input  wire logic             out_ready,
	output      logic             out_valid,
	output      logic [7:0]       packet_byte,
	output      logic [FLD_W-1:0] byte_index,
	output      logic [FLD_W-1:0] byte_count,
	output      logic             last_byte,
	output      logic             checksum_ok,
	output      logic [7:0]       preamble_length,
	output      logic             busy
);

	logic             busy_q;
	pkt_bytes_t       bytes_q;
	logic [CNT_W-1:0] left_q, idx_q, count_q;
	logic             ok_q;
	octet_t           pre_q;
	logic             take;

	assign take = busy_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load.emit) begin
			busy_q <= 1'b1;
		end else if (take && (left_q == CNT_W'(1))) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load.emit) begin
			bytes_q <= load.bytes;
			left_q  <= load.count;
			idx_q   <= '0;
			count_q <= load.count;
			ok_q    <= load.xor_ok;
			pre_q   <= load.preamble;
		end else if (take) begin
			bytes_q <= bytes_q >> 8;
			left_q  <= left_q - CNT_W'(1);
			idx_q   <= idx_q + CNT_W'(1);
		end
	end

	assign busy            = busy_q;
	assign out_valid       = busy_q;
	assign packet_byte     = bytes_q[0];
	assign byte_index      = FLD_W'(idx_q);
	assign byte_count      = FLD_W'(count_q);
	assign last_byte       = (left_q == CNT_W'(1));
	assign checksum_ok     = ok_q;
	assign preamble_length = pre_q;

endmodule
`default_nettype wire

// ===== sv/dcc_bit_packet_receiver_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DCC bit packet receiver
// Decodes sampled DCC line levels into packets and plays each packet out as
// a run of byte words with index, count, last, preamble and checksum status.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Word contents                      Notes
//   bit_in    in   line_level                         one sampled bit per word
//   cfg       in   data[4:0] = preamble threshold     always ready
//   pkt_out   out  byte, index, count, last, ok, pre  one packet byte per word
//
// A sample is taken, one bit per cycle, when offered while bit_in.ready is
// high; its effect on the receiver state is registered at that edge. On the
// end bit the stored packet is copied into the run buffer, which presents
// one byte per cycle while pkt_out.ready is high: a packet of N bytes takes
// N output words. While a run drains, the receiver keeps taking bits; only
// an end-of-byte separator bit waits for the previous run to be taken. Reset
// (arst_n low) returns the receiver to preamble hunt, empties the run buffer
// and sets the threshold to ten. The packet store itself is not reset.
// ----------------------------------------------------------------------------
module dcc_bit_packet_receiver_core import dccrx_pkg::*; (
	input wire logic   clk,
	input wire logic   arst_n,
	dccrx_in_if.sink   bit_in,
	dccrx_cfg_if.sink  cfg,
	dccrx_out_if.source pkt_out
);

	run_load_t load;
	logic      run_busy;

	// The threshold register is a plain register, so writes are never held.
	assign cfg.ready = 1'b1;

	// The bit receiver tracks the protocol phase and assembles bytes into the
	// packet store; it raises load.emit on an accepted end bit.
	dccrx_bit_rx u_bit_rx (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (bit_in.valid),
		.line_level (bit_in.line_level),
		.in_ready   (bit_in.ready),
		.cfg_valid  (cfg.valid),
		.cfg_data   (cfg.data),
		.run_busy   (run_busy),
		.load       (load)
	);

	// The run buffer is the output register: it keeps its own copy of the
	// packet so the receiver can start on the next packet at once.
	dccrx_run_buf u_run_buf (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (load),
		.out_ready       (pkt_out.ready),
		.out_valid       (pkt_out.valid),
		.packet_byte     (pkt_out.packet_byte),
		.byte_index      (pkt_out.byte_index),
		.byte_count      (pkt_out.byte_count),
		.last_byte       (pkt_out.last_byte),
		.checksum_ok     (pkt_out.checksum_ok),
		.preamble_length (pkt_out.preamble_length),
		.busy            (run_busy)
	);

endmodule
`default_nettype wire

// ===== sv/dccrx_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DCC packet receiver checker
// Watches the packet byte channel for consistent runs.
// ----------------------------------------------------------------------------
module dccrx_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] packet_byte,
	input wire logic [2:0] byte_index,
	input wire logic [2:0] byte_count,
	input wire logic       last_byte,
	input wire logic       checksum_ok,
	input wire logic [7:0] preamble_length
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(packet_byte)
			&& $stable(byte_index) && $stable(last_byte)))
		else $error("output word changed while stalled");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_byte) |=> out_valid)
		else $error("packet run broke off before its last byte");

	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_byte) |=>
			((byte_index == 3'($past(byte_index) + 3'd1)) && $stable(byte_count)
			&& $stable(checksum_ok) && $stable(preamble_length)))
		else $error("byte index or packet information wrong within a run");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((byte_index < byte_count)
			&& (last_byte == (3'(byte_index + 3'd1) == byte_count))))
		else $error("last flag does not match index and count");

endmodule

bind dcc_bit_packet_receiver_core dccrx_checker u_dccrx_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (pkt_out.valid),
	.out_ready       (pkt_out.ready),
	.packet_byte     (pkt_out.packet_byte),
	.byte_index      (pkt_out.byte_index),
	.byte_count      (pkt_out.byte_count),
	.last_byte       (pkt_out.last_byte),
	.checksum_ok     (pkt_out.checksum_ok),
	.preamble_length (pkt_out.preamble_length)
);
`default_nettype wire
